>>> rtl/lvem_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and codes of the local variance edge mask
// no dependencies

package lvem_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int WINDOW    = 5;
	localparam int HALF      = WINDOW / 2;
	localparam int HIST      = 8 * MAX_WIDTH;

	localparam int SLOT_W = $clog2(HIST);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = 11;
	localparam int ROW_W  = 16;
	localparam int WT_W   = 6;
	localparam int PIX_W  = 8;
	localparam int VAR_W  = 24;
	localparam int PEND_W = 16;
	localparam int WIN_W  = 3;

	localparam int SUM_W   = 13;
	localparam int SQ_W    = 21;
	localparam int T_W     = 26;
	localparam int VSUM_W  = 29;
	localparam int LHS_W   = 32;
	localparam int RHS_W   = 35;

	localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'(WINDOW - 1);
	localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;
	localparam logic [PEND_W-1:0] MAX_DELAY = PEND_W'((WINDOW - 1) * (MAX_WIDTH + 1));

	localparam logic [WID_W-1:0] RST_WIDTH  = 11'd512;
	localparam logic [ROW_W-1:0] RST_HEIGHT = 16'd512;
	localparam logic [WT_W-1:0]  RST_WEIGHT = 6'd12;
	localparam logic [WID_W-1:0] MIN_WIDTH  = 11'd5;
	localparam logic [WID_W-1:0] TOP_WIDTH  = WID_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0] MIN_HEIGHT = 16'd5;

	localparam int CFG_AW = 4;
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WEIGHT = 2'd2;

	typedef struct packed {
		logic [WID_W-1:0] width;
		logic [ROW_W-1:0] height;
		logic [WT_W-1:0]  weight;
	} cfg_t;

	typedef struct packed {
		logic              load;
		logic [PEND_W-1:0] pending;
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VAR_SCAN,
		ST_VAR_LAST,
		ST_VAR_MUL,
		ST_VAR_WR,
		ST_EMIT_RD,
		ST_EMIT_CTR,
		ST_SUM_SCAN,
		ST_SUM_LAST,
		ST_CMP,
		ST_FIN
	} state_t;

endpackage

>>> rtl/local_variance_edge_mask.sv
`timescale 1ns / 1ps
// top level of the 5x5 local variance edge mask
// depends on lvem_pkg, lvem_cfg, lvem_core and lvem_ram

// Grey pixels stream in raster order; each leaves 4*W+4 data beats later,
// set to 255 where its 5x5 variance falls below weight/10 of the 5x5 mean
// variance, else unchanged; border pixels pass. Drain beats (tuser = 1)
// push out the tail of a frame once the whole frame has been received.
// One beat at a time is handled. A data beat that completes a variance
// window walks its 25 taps, then accumulates, multiplies and writes back;
// an output inside the region takes address, fetch, 25 taps, accumulate,
// compare and load, and a border output takes address, fetch and load. A
// result still untaken holds back the load of the next one. The cost is
// set by the single read port of the pixel and variance line stores,
// walked one window tap per cycle. The output register lets the next beat
// enter while a result still waits to be taken.
// The line stores need no clearing after reset.

module local_variance_edge_mask (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	input  logic        s_tuser,   // [0] operation: 0 data, 1 drain
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] pixel_out
	output logic        m_tlast,   // last beat of the frame
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lvem_pkg::*;

	cfg_t  cfg;
	stat_t stat;

	assign pready = 1'b1;

	// register file, geometry clamped here
	lvem_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer and line stores
	lvem_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_drain  (s_tuser),
		.in_pixel  (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pixel (m_tdata),
		.out_last  (m_tlast),
		.stat      (stat)
	);

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.load |-> (!m_tvalid || m_tready))
		else $error("result loaded over an untaken beat");

	// pending count stays within the longest delay line plus the beat in hand
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.pending <= MAX_DELAY + PEND_W'(1))
		else $error("pending count beyond delay");

	// a result only shows up after a load
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(stat.load))
		else $error("output valid without load");

	// no input taken while a result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.load |-> !s_tready)
		else $error("input ready during output load");

endmodule

>>> rtl/lvem_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read port
// no dependencies

module lvem_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lvem_cfg.sv
`timescale 1ns / 1ps
// apb register file for geometry and threshold weight
// depends on lvem_pkg

module lvem_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lvem_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output lvem_pkg::cfg_t             cfg
);
	import lvem_pkg::*;

	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [WT_W-1:0]  weight_q;
	logic [1:0]       idx;
	logic             wr;

	assign idx = paddr[3:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			weight_q <= RST_WEIGHT;
		end else if (wr) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[WID_W-1:0];
				REG_HEIGHT: height_q <= pwdata[ROW_W-1:0];
				REG_WEIGHT: weight_q <= pwdata[WT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {16'd0, height_q};
			REG_WEIGHT: prdata = {26'd0, weight_q};
			default:    prdata = 32'd0;
		endcase
	end

	// clamp geometry: width to what the line stores hold, both sides to at least the window
	always_comb begin
		cfg.width  = (width_q < MIN_WIDTH) ? MIN_WIDTH :
			(width_q > TOP_WIDTH) ? TOP_WIDTH : width_q;
		cfg.height = (height_q < MIN_HEIGHT) ? MIN_HEIGHT : height_q;
		cfg.weight = weight_q;
	end

endmodule

>>> rtl/lvem_core.sv
`timescale 1ns / 1ps
// sequencer around the pixel and variance line stores
// depends on lvem_pkg and lvem_ram

module lvem_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lvem_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_drain,
	input  logic [lvem_pkg::PIX_W-1:0]  in_pixel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lvem_pkg::PIX_W-1:0]  out_pixel,
	output logic                        out_last,
	output lvem_pkg::stat_t             stat
);
	import lvem_pkg::*;

	state_t state_q, state_d;

	logic [SLOT_W-1:0] ws_q, scan_addr_q, ctr_q, raddr, ctr_addr, var_waddr;
	logic [ROW_W-1:0]  irow_q, orow_q;
	logic [COL_W-1:0]  icol_q, ocol_q;
	logic [PEND_W-1:0] pend_q, pend_inc, delay;
	logic              emit_q;
	logic [WIN_W-1:0]  dy_q, dx_q;
	logic              pv_s1, vv_s1, nb_in;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sumsq_q;
	logic [T_W-1:0]    t1_q, t2_q, vdiff;
	logic [VSUM_W-1:0] vsum_q;
	logic [VAR_W-1:0]  v0_q;
	logic [PIX_W-1:0]  pix_q;
	logic [LHS_W-1:0]  lhs_q;
	logic [RHS_W-1:0]  rhs_q;
	logic              out_valid_q, out_last_q;
	logic [PIX_W-1:0]  out_pixel_q;

	logic              pix_we, var_we, load, accept, scan_end;
	logic              var_region, out_region, drain_ok, emit_now;
	logic [PIX_W-1:0]  pix_rdata;
	logic [VAR_W-1:0]  var_rdata;
	logic [SLOT_W-1:0] w_slot, w2_slot, w4_slot;
	logic signed [ROW_W+1:0] nb_row;
	logic signed [COL_W+1:0] nb_col;

	lvem_ram #(.DEPTH(HIST), .WIDTH(PIX_W)) u_pix_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (ws_q + SLOT_W'(1)),
		.wdata (in_pixel),
		.raddr (raddr),
		.rdata (pix_rdata)
	);

	lvem_ram #(.DEPTH(HIST), .WIDTH(VAR_W)) u_var_ram (
		.clk   (clk),
		.we    (var_we),
		.waddr (var_waddr),
		.wdata (vdiff[VAR_W-1:0]),
		.raddr (raddr),
		.rdata (var_rdata)
	);

	assign w_slot   = SLOT_W'(cfg.width);
	assign w2_slot  = SLOT_W'({cfg.width, 1'b0}) + SLOT_W'(2);
	assign w4_slot  = SLOT_W'({cfg.width, 2'b00}) + SLOT_W'(4);
	assign delay    = PEND_W'({cfg.width, 2'b00}) + PEND_W'(4);
	assign pend_inc = pend_q + PEND_W'(1);
	assign accept   = in_valid && in_ready;
	assign scan_end = (dy_q == WIN_LAST) && (dx_q == WIN_LAST);
	assign ctr_addr = ws_q - pend_q[SLOT_W-1:0] + SLOT_W'(1);
	assign var_waddr = ws_q - w2_slot;
	assign vdiff    = t1_q - t2_q;

	// window centre two rows and columns back lies inside the region
	assign var_region = (irow_q >= ROW_W'(4)) &&
		(({1'b0, irow_q} + 17'd2) <= {1'b0, cfg.height}) &&
		(icol_q >= COL_W'(4)) &&
		(({2'b0, icol_q} + 12'd2) <= {1'b0, cfg.width});
	assign out_region = (orow_q >= ROW_W'(2)) &&
		(({1'b0, orow_q} + 17'd4) <= {1'b0, cfg.height}) &&
		(ocol_q >= COL_W'(2)) &&
		(({2'b0, ocol_q} + 12'd4) <= {1'b0, cfg.width});
	assign drain_ok = (irow_q == '0) && (icol_q == '0) && (pend_q != '0);
	assign emit_now = pend_inc > delay;

	assign nb_row = $signed({2'b00, orow_q}) + $signed({{(ROW_W-1){1'b0}}, dy_q})
		- $signed((ROW_W+2)'(HALF));
	assign nb_col = $signed({2'b00, ocol_q}) + $signed({{(COL_W-1){1'b0}}, dx_q})
		- $signed((COL_W+2)'(HALF));
	assign nb_in = (nb_row >= $signed((ROW_W+2)'(2))) &&
		((nb_row + $signed((ROW_W+2)'(4))) <= $signed({2'b00, cfg.height})) &&
		(nb_col >= $signed((COL_W+2)'(2))) &&
		((nb_col + $signed((COL_W+2)'(4))) <= $signed({1'b0, cfg.width}));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_drain) begin
						state_d = drain_ok ? ST_EMIT_RD : ST_IDLE;
					end else if (var_region) begin
						state_d = ST_VAR_SCAN;
					end else begin
						state_d = emit_now ? ST_EMIT_RD : ST_IDLE;
					end
				end
			end
			ST_VAR_SCAN: if (scan_end) state_d = ST_VAR_LAST;
			ST_VAR_LAST: state_d = ST_VAR_MUL;
			ST_VAR_MUL:  state_d = ST_VAR_WR;
			ST_VAR_WR:   state_d = emit_q ? ST_EMIT_RD : ST_IDLE;
			ST_EMIT_RD:  state_d = ST_EMIT_CTR;
			ST_EMIT_CTR: state_d = out_region ? ST_SUM_SCAN : ST_FIN;
			ST_SUM_SCAN: if (scan_end) state_d = ST_SUM_LAST;
			ST_SUM_LAST: state_d = ST_CMP;
			ST_CMP:      state_d = ST_FIN;
			ST_FIN:      if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		pix_we   = 1'b0;
		var_we   = 1'b0;
		load     = 1'b0;
		raddr    = scan_addr_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				pix_we   = in_valid && !in_drain;
			end
			ST_VAR_WR:  var_we = 1'b1;
			ST_EMIT_RD: raddr  = ctr_addr;
			ST_FIN:     load   = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ws_q        <= '1;
			irow_q      <= '0;
			icol_q      <= '0;
			orow_q      <= '0;
			ocol_q      <= '0;
			pend_q      <= '0;
			emit_q      <= 1'b0;
			dy_q        <= '0;
			dx_q        <= '0;
			pv_s1       <= 1'b0;
			vv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= (state_q == ST_VAR_SCAN);
			vv_s1   <= (state_q == ST_SUM_SCAN) && nb_in;

			if (state_q == ST_IDLE && accept && !in_drain) begin
				ws_q   <= ws_q + SLOT_W'(1);
				pend_q <= pend_inc;
				emit_q <= emit_now;
				if (({1'b0, icol_q} + 11'd1) >= cfg.width) begin
					icol_q <= '0;
					irow_q <= (({1'b0, irow_q} + 17'd1) >= {1'b0, cfg.height}) ?
						'0 : irow_q + ROW_W'(1);
				end else begin
					icol_q <= icol_q + COL_W'(1);
				end
			end

			// window tap walk, row by row
			if (state_q == ST_VAR_SCAN || state_q == ST_SUM_SCAN) begin
				if (dx_q == WIN_LAST) begin
					dx_q <= '0;
					dy_q <= dy_q + WIN_W'(1);
				end else begin
					dx_q <= dx_q + WIN_W'(1);
				end
			end else begin
				dx_q <= '0;
				dy_q <= '0;
			end

			if (load) begin
				out_valid_q <= 1'b1;
				pend_q      <= pend_q - PEND_W'(1);
				if (({1'b0, ocol_q} + 11'd1) >= cfg.width) begin
					ocol_q <= '0;
					orow_q <= (({1'b0, orow_q} + 17'd1) >= {1'b0, cfg.height}) ?
						'0 : orow_q + ROW_W'(1);
				end else begin
					ocol_q <= ocol_q + COL_W'(1);
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			scan_addr_q <= ws_q + SLOT_W'(1) - w4_slot;
			sum_q       <= '0;
			sumsq_q     <= '0;
		end
		if (state_q == ST_VAR_SCAN || state_q == ST_SUM_SCAN) begin
			scan_addr_q <= (dx_q == WIN_LAST) ?
				scan_addr_q + w_slot - SLOT_W'(WINDOW - 1) : scan_addr_q + SLOT_W'(1);
		end
		if (pv_s1) begin
			sum_q   <= sum_q + SUM_W'(pix_rdata);
			sumsq_q <= sumsq_q + SQ_W'(pix_rdata * pix_rdata);
		end
		if (state_q == ST_VAR_MUL) begin
			t1_q <= T_W'(sumsq_q * SQ_W'(WINDOW * WINDOW));
			t2_q <= T_W'(sum_q * sum_q);
		end
		if (state_q == ST_EMIT_RD) begin
			ctr_q <= ctr_addr;
		end
		if (state_q == ST_EMIT_CTR) begin
			pix_q       <= pix_rdata;
			v0_q        <= var_rdata;
			vsum_q      <= '0;
			scan_addr_q <= ctr_q - w2_slot;
			lhs_q       <= '0;
			rhs_q       <= '0;
		end
		if (vv_s1) begin
			vsum_q <= vsum_q + VSUM_W'(var_rdata);
		end
		// 250*v0 against weight*sum keeps the tenths and the 1/25 exact
		if (state_q == ST_CMP) begin
			lhs_q <= LHS_W'(v0_q * 8'd250);
			rhs_q <= RHS_W'(vsum_q * cfg.weight);
		end
		if (load) begin
			out_pixel_q <= ({3'b000, lhs_q} < rhs_q) ? PIX_MAX : pix_q;
			out_last_q  <= (orow_q == cfg.height - ROW_W'(1)) &&
				({1'b0, ocol_q} == cfg.width - WID_W'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pixel    = out_pixel_q;
	assign out_last     = out_last_q;
	assign stat.load    = load;
	assign stat.pending = pend_q;

endmodule

>>> bench/local_variance_edge_mask_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the 5x5 local variance edge mask
// depends on lvem_pkg and local_variance_edge_mask

module local_variance_edge_mask_tb;
	import lvem_pkg::*;

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// expected-pixel store plus a bit-exact copy of the mask arithmetic
	class edge_mask_board;
		int unsigned width_reg, height_reg, weight_reg;
		byte unsigned pix_hist [HIST];
		int unsigned var_hist [HIST];
		longint wr_slot, in_row, in_col, out_row, out_col, pending;
		bit [8:0] expected [$];   // {last, pixel}
		int errors, seen;

		function new();
			width_reg = RST_WIDTH;
			height_reg = RST_HEIGHT;
			weight_reg = RST_WEIGHT;
			foreach (pix_hist[i]) begin
				pix_hist[i] = 0;
				var_hist[i] = 0;
			end
			wr_slot = HIST - 1;
			in_row = 0; in_col = 0; out_row = 0; out_col = 0; pending = 0;
			errors = 0; seen = 0;
		endfunction

		function void write_reg(int idx, logic [31:0] val);
			if (idx == REG_WIDTH) width_reg = val[10:0];
			else if (idx == REG_HEIGHT) height_reg = val[15:0];
			else if (idx == REG_WEIGHT) weight_reg = val[5:0];
		endfunction

		function longint eff_w();
			if (width_reg < 5) return 5;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return width_reg;
		endfunction

		function longint eff_h();
			return (height_reg < 5) ? 5 : height_reg;
		endfunction

		function int slot(longint back);
			longint s;
			s = (wr_slot - back) % HIST;
			if (s < 0) s += HIST;
			return int'(s);
		endfunction

		function bit in_reg(longint r, longint c, longint w, longint h);
			return r >= HALF && r + HALF + 2 <= h && c >= HALF && c + HALF + 2 <= w;
		endfunction

		// oldest pending pixel leaves, masked to 255 where its variance is low
		function void emit(longint w, longint h);
			longint d, s, v0;
			bit [7:0] pix;
			d = pending - 1;
			pix = pix_hist[slot(d)];
			if (in_reg(out_row, out_col, w, h)) begin
				v0 = var_hist[slot(d)];
				s = 0;
				for (int dy = -HALF; dy <= HALF; dy++)
					for (int dx = -HALF; dx <= HALF; dx++)
						if (in_reg(out_row + dy, out_col + dx, w, h))
							s += var_hist[slot(d - dy * w - dx)];
				if (250 * v0 < weight_reg * s) pix = PIX_MAX;
			end
			expected.push_back({(out_row == h - 1 && out_col == w - 1), pix});
			if (out_col + 1 >= w) begin
				out_col = 0;
				out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
			end else begin
				out_col++;
			end
			pending--;
		endfunction

		function void note_input(logic op, logic [7:0] pixel);
			longint w, h, sum, sumsq, p;
			w = eff_w();
			h = eff_h();
			if (op == OP_DATA) begin
				wr_slot = (wr_slot + 1) % HIST;
				pix_hist[wr_slot] = pixel;
				if (in_reg(in_row - HALF, in_col - HALF, w, h)) begin
					sum = 0; sumsq = 0;
					for (int dy = -HALF; dy <= HALF; dy++)
						for (int dx = -HALF; dx <= HALF; dx++) begin
							p = pix_hist[slot((HALF - dy) * w + (HALF - dx))];
							sum += p;
							sumsq += p * p;
						end
					var_hist[slot(HALF * w + HALF)] =
						int'((25 * sumsq - sum * sum) & 24'hFFFFFF);
				end
				if (in_col + 1 >= w) begin
					in_col = 0;
					in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
				end else begin
					in_col++;
				end
				pending++;
				if (pending > (WINDOW - 1) * (w + 1)) emit(w, h);
			end else if (in_row == 0 && in_col == 0 && pending > 0) begin
				emit(w, h);
			end
		endfunction

		function void check(logic [7:0] pixel, logic last);
			bit [8:0] want;
			seen++;
			if (expected.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got pixel %0d last %0d",
					$time, pixel, last);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (want[7:0] !== pixel) begin
				$display("%0t: pixel_out mismatch, expected %0d, got %0d", $time, want[7:0], pixel);
				errors++;
			end
			if (want[8] !== last) begin
				$display("%0t: last_of_frame mismatch, expected %0d, got %0d", $time, want[8], last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	edge_mask_board board = new();
	bit calm;          // no random gaps on either side while set
	bit hold_req;      // asks the receiver for one long hold-off
	int data_sent;

	local_variance_edge_mask dut (.*);

	always #5 clk = ~clk;

	// gap draw shared by both sides
	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin : receiver
		int gap;
		forever begin
			gap = draw_gap();
			if (hold_req) begin
				hold_req = 0;
				gap = 400;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check(m_tdata, m_tlast);
		end
	end

	// one slave beat; valid stays high across back-to-back beats
	task automatic send(logic op, logic [7:0] pixel);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= pixel;
		do @(posedge clk); while (!s_tready);
		board.note_input(op, pixel);
		if (op == OP_DATA) data_sent++;
	endtask

	// setup then access phase; register takes the value at the access edge
	task automatic write_reg(int idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.write_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// block idle: all results back, then room for a beat that gives none
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.expected.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic flush();
		while (board.pending > 0) send(OP_DRAIN, 8'd0);
	endtask

	// whole frames of random content; style picks noise, smooth or flat areas
	task automatic run_frames(int frames, int w, int h, bit noisy_drains);
		int style, base;
		logic [7:0] px;
		for (int f = 0; f < frames; f++) begin
			style = $urandom_range(0, 2);
			base = $urandom_range(0, 255);
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < w * h; i++) begin
				// drains in mid-frame are ignored by the block; one at a frame start pushes out a pending beat
				if (noisy_drains && $urandom_range(0, 19) == 0) send(OP_DRAIN, 8'($urandom));
				case (style)
					0: px = 8'($urandom);
					1: px = 8'(base + $urandom_range(0, 12));
					default: px = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(base);
				endcase
				send(OP_DATA, px);
				if (board.seen >= 60 && !hold_req && data_sent < 400 && data_sent > 300)
					hold_req = 1;
			end
		end
		calm = 0;
	endtask

	initial begin : stimulus
		int w, h, wt;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// drain with nothing pending
		send(OP_DRAIN, 8'hFF);
		settle();

		// directed: smallest frame with a variance region, checkerboard of extremes
		write_reg(REG_WIDTH, 6);
		write_reg(REG_HEIGHT, 6);
		write_reg(REG_WEIGHT, 63);
		write_reg(3, 32'hFFFF_FFFF);   // unmapped register, ignored
		for (int i = 0; i < 36; i++) begin
			if (i == 10) send(OP_DRAIN, 8'd0);   // mid-frame drain, no effect
			send(OP_DATA, ((i / 6 + i) % 2) ? 8'hFF : 8'h00);
		end
		flush();
		send(OP_DRAIN, 8'd0);
		settle();

		// random phases of small frames, some back to back without drain
		while (data_sent < 500) begin
			w = ($urandom_range(0, 4) == 0) ? 5 : $urandom_range(5, 12);
			h = $urandom_range(5, 9);
			case ($urandom_range(0, 3))
				0: wt = 0;
				1: wt = 63;
				default: wt = $urandom_range(0, 63);
			endcase
			write_reg(REG_WIDTH, w);
			write_reg(REG_HEIGHT, h);
			write_reg(REG_WEIGHT, wt);
			run_frames($urandom_range(1, 2), w, h, 1);
			flush();
			settle();
		end

		// out-of-range geometry: height clamps to 5, then width clamps to 5
		write_reg(REG_WIDTH, 7);
		write_reg(REG_HEIGHT, 0);
		write_reg(REG_WEIGHT, 0);
		run_frames(1, 7, 5, 0);
		flush();
		settle();
		write_reg(REG_WIDTH, 0);
		write_reg(REG_WEIGHT, 40);
		run_frames(1, 5, 5, 0);
		flush();
		settle();

		// tallest frame, never completed; only the early outputs are checked
		write_reg(REG_WIDTH, 5);
		write_reg(REG_HEIGHT, 16'hFFFF);
		write_reg(REG_WEIGHT, 20);
		for (int i = 0; i < 150; i++) send(OP_DATA, 8'($urandom));
		settle();

		if (board.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin : watchdog
		#30ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
rtl/lvem_pkg.sv
rtl/lvem_ram.sv
rtl/lvem_cfg.sv
rtl/lvem_core.sv
rtl/local_variance_edge_mask.sv
bench/local_variance_edge_mask_tb.sv
